// ===== design/sdfg_pkg.sv =====
package sdfg_pkg;

    localparam int MAX_USED_FEATURES = 32;
    localparam int ID_BITS           = 24;

    localparam int OPCODE_W      = 2;
    localparam int FEATURE_ID_W  = 24;
    localparam int VALUE_W       = 64;
    localparam int POSITION_W    = 6;

    localparam int ID_W   = (ID_BITS < FEATURE_ID_W) ? ID_BITS : FEATURE_ID_W;
    localparam int CNT_W  = $clog2(MAX_USED_FEATURES + 1);
    localparam int IDX_W  = (MAX_USED_FEATURES > 1) ? $clog2(MAX_USED_FEATURES) : 1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_ELEM  = 2'd1,
        OP_END   = 2'd2,
        OP_CLEAR = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t                   opcode;
        logic [FEATURE_ID_W-1:0]   feature_id;
        logic [VALUE_W-1:0]        feature_value;
    } in_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0]        dense_value;
        logic [POSITION_W-1:0]     dense_position;
        logic                      run_last;
        logic                      instance_last;
    } out_word_t;

endpackage

// ===== design/sparse_to_dense_feature_gather.sv =====
// Timing: the table is read at acceptance, and the first dense word of a run goes to the
// pending register in ST_EMIT and shows on m_valid when the next slot is emitted or in ST_FLUSH;
// one table entry is compared per cycle while the output is not stalled. A load or clear word
// is taken with s_ready staying high, as is an element or end word when the cursor has no slot
// left; otherwise s_ready stays low until the run has been flushed, and output stalls hold it.
// Reset: aresetn is synchronous, active low; it clears the table count, the cursor and
// the handshake state. The id table itself is not cleared.
module sparse_to_dense_feature_gather (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sdfg_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sdfg_pkg::out_word_t  m_data
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EMIT  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    logic [sdfg_pkg::ID_W-1:0] used_id_table [sdfg_pkg::MAX_USED_FEATURES];

    state_t                         state_reg, state_next;
    logic [sdfg_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [sdfg_pkg::CNT_W-1:0]     cursor_reg, cursor_next;
    sdfg_pkg::opcode_t              op_reg, op_next;
    logic [sdfg_pkg::ID_W-1:0]      id_reg, id_next;
    logic [sdfg_pkg::VALUE_W-1:0]   value_reg, value_next;
    logic [sdfg_pkg::ID_W-1:0]      rd_data_reg;
    logic                           pend_valid_reg, pend_valid_next;
    sdfg_pkg::out_word_t            pend_reg, pend_next;
    logic                           m_valid_reg, m_valid_next;
    sdfg_pkg::out_word_t            m_word_reg, m_word_next;

    logic                           accept;
    logic                           wr_en;
    logic                           can_push;
    logic                           id_gt;
    logic                           id_eq;
    logic                           do_emit;
    logic                           last_slot;
    logic                           run_done;
    logic [sdfg_pkg::CNT_W-1:0]     cursor_inc;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign can_push = !m_valid_reg || m_ready;

    assign cursor_inc = sdfg_pkg::CNT_W'(cursor_reg + sdfg_pkg::CNT_W'(1));
    assign last_slot  = (cursor_inc == count_reg);
    assign id_gt      = (id_reg > rd_data_reg);
    assign id_eq      = (id_reg == rd_data_reg);
    assign do_emit    = (op_reg == sdfg_pkg::OP_END) || id_gt || id_eq;
    assign run_done   = !do_emit || ((op_reg == sdfg_pkg::OP_ELEM) && id_eq) || last_slot;

    assign wr_en = accept && (s_data.opcode == sdfg_pkg::OP_LOAD)
                   && (count_reg < sdfg_pkg::CNT_W'(sdfg_pkg::MAX_USED_FEATURES));

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        value_next      = value_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_word_next     = m_word_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next    = s_data.opcode;
                    id_next    = s_data.feature_id[sdfg_pkg::ID_W-1:0];
                    value_next = s_data.feature_value;
                    case (s_data.opcode)
                        sdfg_pkg::OP_LOAD: begin
                            if (wr_en) begin
                                count_next = sdfg_pkg::CNT_W'(count_reg + sdfg_pkg::CNT_W'(1));
                            end
                        end
                        sdfg_pkg::OP_ELEM, sdfg_pkg::OP_END: begin
                            if (cursor_reg < count_reg) begin
                                state_next = ST_EMIT;
                            end else if (s_data.opcode == sdfg_pkg::OP_END) begin
                                cursor_next = '0;
                            end
                        end
                        default: begin
                            count_next  = '0;
                            cursor_next = '0;
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                if (can_push) begin
                    if (do_emit) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_word_next  = pend_reg;
                        end
                        pend_valid_next          = 1'b1;
                        pend_next.dense_value    = (op_reg == sdfg_pkg::OP_ELEM && id_eq)
                                                   ? value_reg : '0;
                        pend_next.dense_position = sdfg_pkg::POSITION_W'(cursor_reg);
                        pend_next.run_last       = 1'b0;
                        pend_next.instance_last  = last_slot;
                        cursor_next              = cursor_inc;
                    end
                    if (run_done) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || can_push) begin
                    if (pend_valid_reg) begin
                        m_valid_next         = 1'b1;
                        m_word_next          = pend_reg;
                        m_word_next.run_last = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                    if (op_reg == sdfg_pkg::OP_END) begin
                        cursor_next = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            used_id_table[count_reg[sdfg_pkg::IDX_W-1:0]] <= s_data.feature_id[sdfg_pkg::ID_W-1:0];
        end
        rd_data_reg <= used_id_table[cursor_next[sdfg_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            cursor_reg     <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            cursor_reg     <= cursor_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        value_reg  <= value_next;
        pend_reg   <= pend_next;
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_word_reg;

endmodule

// ===== design/sdfg_checker.sv =====
module sdfg_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input sdfg_pkg::in_word_t   s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input sdfg_pkg::out_word_t  m_data
);

    logic [sdfg_pkg::OPCODE_W-1:0] s_opcode;
    assign s_opcode = s_data.opcode;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_instance_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.instance_last |-> m_data.run_last)
        else $error("final slot of instance without run end");

    a_busy_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.run_last |-> !s_ready)
        else $error("input taken while a run is still open");

    a_load_single_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_opcode == sdfg_pkg::OP_LOAD) |=> s_ready)
        else $error("load word stalled the input");

endmodule

bind sparse_to_dense_feature_gather sdfg_checker u_sdfg_checker (.*);

// ===== sim/sparse_to_dense_feature_gather_tb.sv =====
`timescale 1ns / 1ps

module sparse_to_dense_feature_gather_tb;

    localparam int GAP_MAX      = 14;
    localparam int HOLD_AT      = 20;
    localparam int HOLD_LEN     = 500;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_WORDS = 230;
    localparam int ID_MAX       = 'hFF_FFFF;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    sdfg_pkg::in_word_t  s_data      = '0;
    logic                m_valid;
    logic                m_ready;
    sdfg_pkg::out_word_t m_data;
    logic                rx_ready    = 1'b0;
    logic                hold_active = 1'b0;
    logic                hold_done   = 1'b0;

    logic [sdfg_pkg::ID_W-1:0] gather_ids [sdfg_pkg::MAX_USED_FEATURES];
    int                        gather_count  = 0;
    int                        gather_cursor = 0;

    sdfg_pkg::in_word_t  word_q [$];
    sdfg_pkg::out_word_t dense_q [$];

    int errors      = 0;
    int words_total = 0;
    int words_in    = 0;
    int slots_out   = 0;
    int gap_left    = 0;
    int rx_wait     = 0;
    int rx_draw     = 0;
    int hold_cnt    = 0;
    int idle_cycles = 0;
    int directed_n  = 0;
    int pick;
    bit tx_burst    = 1'b0;
    bit rx_burst    = 1'b0;

    assign m_ready = rx_ready && !hold_active;

    sparse_to_dense_feature_gather u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic logic [sdfg_pkg::VALUE_W-1:0] rand_value();
        return {$urandom(), $urandom()};
    endfunction

    function automatic sdfg_pkg::out_word_t make_slot(input logic [sdfg_pkg::VALUE_W-1:0] v);
        sdfg_pkg::out_word_t s;
        s.dense_value    = v;
        s.dense_position = sdfg_pkg::POSITION_W'(gather_cursor);
        s.run_last       = 1'b0;
        s.instance_last  = (gather_cursor + 1 == gather_count);
        return s;
    endfunction

    task automatic predict_gather(input sdfg_pkg::in_word_t w);
        sdfg_pkg::out_word_t       run [$];
        logic [sdfg_pkg::ID_W-1:0] id;
        id = w.feature_id[sdfg_pkg::ID_W-1:0];
        case (w.opcode)
            sdfg_pkg::OP_LOAD: begin
                if (gather_count < sdfg_pkg::MAX_USED_FEATURES) begin
                    gather_ids[gather_count] = id;
                    gather_count++;
                end
            end
            sdfg_pkg::OP_ELEM, sdfg_pkg::OP_END: begin
                while (gather_cursor < gather_count &&
                       (w.opcode == sdfg_pkg::OP_END || id > gather_ids[gather_cursor])) begin
                    run = {run, make_slot('0)};
                    gather_cursor++;
                end
                if (w.opcode == sdfg_pkg::OP_ELEM && gather_cursor < gather_count &&
                    id == gather_ids[gather_cursor]) begin
                    run = {run, make_slot(w.feature_value)};
                    gather_cursor++;
                end
                if (w.opcode == sdfg_pkg::OP_END) begin
                    gather_cursor = 0;
                end
            end
            default: begin
                gather_count  = 0;
                gather_cursor = 0;
            end
        endcase
        if (run.size() > 0) begin
            run[run.size() - 1].run_last = 1'b1;
        end
        dense_q = {dense_q, run};
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        if (errors < 40) begin
            $display("MISMATCH %s at slot %0d: got %h, want %h", what, slots_out, got, want);
        end
        errors++;
    endtask

    task automatic check_slot(input sdfg_pkg::out_word_t got);
        sdfg_pkg::out_word_t want;
        if (dense_q.size() == 0) begin
            report("unexpected dense slot", got.dense_value, '0);
        end else begin
            want = dense_q.pop_front();
            if (got.dense_value !== want.dense_value)
                report("dense_value", got.dense_value, want.dense_value);
            if (got.dense_position !== want.dense_position)
                report("dense_position", 64'(got.dense_position), 64'(want.dense_position));
            if (got.run_last !== want.run_last)
                report("run_last", 64'(got.run_last), 64'(want.run_last));
            if (got.instance_last !== want.instance_last)
                report("instance_last", 64'(got.instance_last), 64'(want.instance_last));
        end
    endtask

    task automatic add_word(input sdfg_pkg::opcode_t op, input int id,
                            input logic [sdfg_pkg::VALUE_W-1:0] v);
        sdfg_pkg::in_word_t w;
        w.opcode        = op;
        w.feature_id    = sdfg_pkg::FEATURE_ID_W'(id);
        w.feature_value = v;
        word_q = {word_q, w};
        words_total++;
    endtask

    task automatic add_session(input int n_ids, input bit do_clear);
        int ids [$];
        int step;
        int id;
        int prev;
        if (do_clear) add_word(sdfg_pkg::OP_CLEAR, $urandom_range(0, ID_MAX), rand_value());
        step = ID_MAX / n_ids;
        id   = $urandom_range(0, step);
        for (int i = 0; i < n_ids; i++) begin
            ids = {ids, id};
            add_word(sdfg_pkg::OP_LOAD, id, rand_value());
            id += $urandom_range(1, step);
        end
        repeat ($urandom_range(1, 3)) begin
            prev = -1;
            foreach (ids[i]) begin
                if ($urandom_range(0, 5) == 0 && ids[i] - prev > 1)
                    add_word(sdfg_pkg::OP_ELEM, $urandom_range(prev + 1, ids[i] - 1),
                             rand_value());
                if ($urandom_range(0, 1) == 0)
                    add_word(sdfg_pkg::OP_ELEM, ids[i], rand_value());
                prev = ids[i];
            end
            if ($urandom_range(0, 5) == 0 && prev < ID_MAX)
                add_word(sdfg_pkg::OP_ELEM, $urandom_range(prev + 1, ID_MAX), rand_value());
            if ($urandom_range(0, 9) == 0)
                add_word(sdfg_pkg::OP_ELEM, $urandom_range(0, ID_MAX), rand_value());
            if ($urandom_range(0, 19) == 0)
                add_word(sdfg_pkg::OP_LOAD, $urandom_range(0, ID_MAX), rand_value());
            if ($urandom_range(0, 9) != 0)
                add_word(sdfg_pkg::OP_END, $urandom_range(0, ID_MAX), rand_value());
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
            words_in <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_gather(s_data);
                words_in <= words_in + 1;
                if ($urandom_range(0, 29) == 0) tx_burst <= !tx_burst;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    s_valid  <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (word_q.size() > 0) begin
                    s_data   <= word_q.pop_front();
                    s_valid  <= 1'b1;
                    gap_left <= draw_wait(tx_burst);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_ready  <= 1'b0;
            rx_wait   <= 0;
            slots_out <= 0;
        end else if (m_valid && m_ready) begin
            check_slot(m_data);
            slots_out <= slots_out + 1;
            if ($urandom_range(0, 29) == 0) rx_burst <= !rx_burst;
            rx_draw = draw_wait(rx_burst);
            if (rx_draw == 0) begin
                rx_ready <= 1'b1;
            end else begin
                rx_ready <= 1'b0;
                rx_wait  <= rx_draw;
            end
        end else if (!rx_ready) begin
            if (rx_wait <= 1) begin
                rx_ready <= 1'b1;
                rx_wait  <= 0;
            end else begin
                rx_wait <= rx_wait - 1;
            end
        end
    end

    // hold off the output once, long enough to back up the input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_active <= 1'b0;
            hold_done   <= 1'b0;
            hold_cnt    <= 0;
        end else if (hold_active) begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_LEN - 1) begin
                hold_active <= 1'b0;
                hold_done   <= 1'b1;
            end
        end else if (!hold_done && slots_out >= HOLD_AT) begin
            hold_active <= 1'b1;
            hold_cnt    <= 0;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        add_word(sdfg_pkg::OP_CLEAR, 0, '0);
        add_word(sdfg_pkg::OP_ELEM, $urandom_range(0, ID_MAX), rand_value());
        add_word(sdfg_pkg::OP_END, 0, '0);
        add_word(sdfg_pkg::OP_LOAD, 'h00_0000, '0);
        add_word(sdfg_pkg::OP_LOAD, 'h00_0100, '0);
        add_word(sdfg_pkg::OP_LOAD, 'h7F_0000, '0);
        add_word(sdfg_pkg::OP_LOAD, 'hFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        add_word(sdfg_pkg::OP_ELEM, 'h00_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        add_word(sdfg_pkg::OP_ELEM, 'h00_0050, rand_value());
        add_word(sdfg_pkg::OP_ELEM, 'h7F_0000, 64'h0);
        add_word(sdfg_pkg::OP_END, ID_MAX, 64'hFFFF_FFFF_FFFF_FFFF);
        add_word(sdfg_pkg::OP_ELEM, 'hFF_FFFF, 64'h5555_5555_5555_5555);
        add_word(sdfg_pkg::OP_ELEM, 'hFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA);
        add_word(sdfg_pkg::OP_END, 0, '0);
        add_word(sdfg_pkg::OP_ELEM, 'h80_0000, rand_value());
        add_word(sdfg_pkg::OP_LOAD, 'h00_0010, '0);
        add_word(sdfg_pkg::OP_END, 0, '0);
        add_word(sdfg_pkg::OP_ELEM, 'h00_0010, rand_value());
        add_word(sdfg_pkg::OP_END, 0, '0);
        add_word(sdfg_pkg::OP_CLEAR, ID_MAX, 64'hFFFF_FFFF_FFFF_FFFF);
        add_word(sdfg_pkg::OP_ELEM, 5, rand_value());
        add_word(sdfg_pkg::OP_LOAD, 5, '0);
        add_word(sdfg_pkg::OP_ELEM, 5, rand_value());
        add_word(sdfg_pkg::OP_END, 0, '0);
        directed_n = words_total;

        add_session(sdfg_pkg::MAX_USED_FEATURES + 2, 1'b1);
        while (words_total < directed_n + RANDOM_WORDS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                add_session($urandom_range(sdfg_pkg::MAX_USED_FEATURES - 2,
                                           sdfg_pkg::MAX_USED_FEATURES + 2),
                            $urandom_range(0, 1));
            end else if (pick < 3) begin
                repeat (4) add_word(sdfg_pkg::opcode_t'($urandom_range(0, 3)),
                                    $urandom_range(0, ID_MAX), rand_value());
            end else begin
                add_session($urandom_range(1, 8), $urandom_range(0, 6) != 0);
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (words_in != words_total) @(posedge aclk);
        while (dense_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Drove %0d words (loads, sparse elements, instance ends, clears), %0d directed",
                 words_total, directed_n);
        $display("Checked %0d dense slots, with one %0d-cycle output stall", slots_out, HOLD_LEN);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/sdfg_pkg.sv
design/sparse_to_dense_feature_gather.sv
design/sdfg_checker.sv
sim/sparse_to_dense_feature_gather_tb.sv
